[hdl/ils_pkg.sv]
`default_nettype none
package ils_pkg;

    localparam int REQ_W      = 3;
    localparam int POS_W      = 5;
    localparam int VAL_PORT_W = 32;
    localparam int STAT_W     = 2;
    localparam int CNT_PORT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_FRONT = 3'd0,
        REQ_ADD_REAR  = 3'd1,
        REQ_REM_FRONT = 3'd2,
        REQ_REM_REAR  = 3'd3,
        REQ_INS_AT    = 3'd4,
        REQ_REM_AT    = 3'd5
    } t_req_type;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type        req_type;
        logic [POS_W-1:0] position;
    } t_req_ctl;

    typedef struct packed {
        t_status status;
        logic    is_empty;
    } t_rsp_stat;

endpackage
`default_nettype wire

[hdl/ils_core.sv]
`default_nettype none
module ils_core #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire ils_pkg::t_req_ctl             i_ctl,
    input  wire logic [ils_pkg::VAL_PORT_W-1:0] i_value,
    output logic [ils_pkg::VAL_PORT_W-1:0]     o_removed_value,
    output ils_pkg::t_rsp_stat                 o_stat,
    output logic [ils_pkg::CNT_PORT_W-1:0]     o_entry_count
);
    import ils_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [VALUE_WIDTH-1:0] r_entries [CAPACITY];
    logic [VALUE_WIDTH-1:0] n_entries [CAPACITY];
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;

    logic [VALUE_WIDTH-1:0] w_in_val;
    logic [VALUE_WIDTH-1:0] w_take_val;
    logic [VAL_PORT_W-1:0]  w_take_ext;
    logic                   w_put;
    logic                   w_take;
    logic [IW-1:0]          w_idx;
    t_status                w_status;
    logic [PW-1:0]          w_pos;
    logic [PW-1:0]          w_cnt;
    logic                   w_full;
    logic                   w_empty;

    // stored width may differ from the 32-bit port
    if (VALUE_WIDTH <= VAL_PORT_W) begin : g_narrow
        assign w_in_val   = i_value[VALUE_WIDTH-1:0];
        assign w_take_ext = VAL_PORT_W'(w_take_val);
    end else begin : g_wide
        assign w_in_val   = VALUE_WIDTH'(i_value);
        assign w_take_ext = w_take_val[VAL_PORT_W-1:0];
    end

    always_comb begin
        w_pos    = PW'(i_ctl.position);
        w_cnt    = PW'(r_count);
        w_full   = (r_count == CW'(CAPACITY));
        w_empty  = (r_count == '0);
        w_put    = 1'b0;
        w_take   = 1'b0;
        w_idx    = '0;
        w_status = ST_OK;
        case (i_ctl.req_type)
            REQ_ADD_FRONT, REQ_ADD_REAR: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_put = 1'b1;
                    w_idx = (i_ctl.req_type == REQ_ADD_FRONT) ? '0 : IW'(r_count);
                end
            end
            REQ_REM_FRONT, REQ_REM_REAR: begin
                if (w_empty) begin
                    w_status = ST_UNDER;
                end else begin
                    w_take = 1'b1;
                    w_idx  = (i_ctl.req_type == REQ_REM_FRONT) ? '0
                                                              : IW'(r_count - CW'(1));
                end
            end
            REQ_INS_AT: begin
                // range is checked before fullness
                if (w_pos == '0 || w_pos > w_cnt + PW'(1)) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_put = 1'b1;
                    w_idx = IW'(w_pos - PW'(1));
                end
            end
            REQ_REM_AT: begin
                if (w_pos == '0 || w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_take = 1'b1;
                    w_idx  = IW'(w_pos - PW'(1));
                end
            end
            default: begin
            end
        endcase

        if (w_put) begin
            n_count = r_count + CW'(1);
        end else if (w_take) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    assign w_take_val = r_entries[w_idx];

    // every cell picks from itself, a neighbor or the new value, so all shift together
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_prev;
        logic [VALUE_WIDTH-1:0] w_next;

        if (k == 0) begin : g_first
            assign w_prev = w_in_val;
        end else begin : g_prev
            assign w_prev = r_entries[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_next = r_entries[k];
        end else begin : g_next
            assign w_next = r_entries[k+1];
        end

        always_comb begin
            n_entries[k] = r_entries[k];
            if (w_put && IW'(k) == w_idx) begin
                n_entries[k] = w_in_val;
            end else if (w_put && IW'(k) > w_idx) begin
                n_entries[k] = w_prev;
            end else if (w_take && IW'(k) >= w_idx) begin
                n_entries[k] = w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entries <= n_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

    assign o_removed_value = w_take ? w_take_ext : '0;
    assign o_stat.status   = w_status;
    assign o_stat.is_empty = (n_count == '0);
    assign o_entry_count   = CNT_PORT_W'(n_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_put |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the list by one");

    a_under_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_status == ST_UNDER |-> r_count == '0)
        else $error("underflow reported on a non-empty list");

    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_status != ST_OK |=> $stable(r_count))
        else $error("failed request changed the count");

endmodule
`default_nettype wire

[hdl/indexed_list_store_top.sv]
// Ordered list of up to CAPACITY values (front is position 1). Each request
// adds at the front or rear, removes from the front or rear, or inserts or
// removes at a 1-based position; removals return the value taken out and
// every request yields one result with status, the new count and an empty
// flag. One request is taken per cycle while o_stall is low: requests land
// in an input register, and the whole cell array shifts in the cycle that
// moves a request into the result register, so a result passes through the
// input register and then the result register, and back-to-back requests
// see each other's updates. Stall on the result side holds the result
// register and, once the input register is also full, stalls the request
// side.
`default_nettype none
module indexed_list_store_top #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [ils_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic [ils_pkg::POS_W-1:0]      i_position,
    input  wire logic [ils_pkg::VAL_PORT_W-1:0] i_value,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [ils_pkg::VAL_PORT_W-1:0]      o_removed_value,
    output logic [ils_pkg::STAT_W-1:0]          o_status,
    output logic [ils_pkg::CNT_PORT_W-1:0]      o_entry_count,
    output logic                                o_is_empty
);
    import ils_pkg::*;

    logic                  r_in_valid;
    t_req_ctl              r_ctl;
    logic [VAL_PORT_W-1:0] r_value;

    logic                  r_out_valid;
    logic [VAL_PORT_W-1:0] r_removed_value;
    t_status               r_status;
    logic [CNT_PORT_W-1:0] r_entry_count;
    logic                  r_is_empty;

    logic                  w_adv;
    logic [VAL_PORT_W-1:0] w_removed_value;
    t_rsp_stat             w_stat;
    logic [CNT_PORT_W-1:0] w_entry_count;

    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ctl.req_type <= t_req_type'(i_req_type);
            r_ctl.position <= i_position;
            r_value        <= i_value;
        end
    end

    ils_core #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_adv),
        .i_ctl           (r_ctl),
        .i_value         (r_value),
        .o_removed_value (w_removed_value),
        .o_stat          (w_stat),
        .o_entry_count   (w_entry_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_removed_value <= w_removed_value;
            r_status        <= w_stat.status;
            r_entry_count   <= w_entry_count;
            r_is_empty      <= w_stat.is_empty;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_removed_value;
    assign o_status        = r_status;
    assign o_entry_count   = r_entry_count;
    assign o_is_empty      = r_is_empty;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
    import ils_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_SEGS = 7;
    localparam int SEG_ITEMS   = 250;

    // request codes with no operation behind them
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [VAL_PORT_W-1:0] removed;
        t_status               status;
        logic [CNT_PORT_W-1:0] count;
        logic                  empty;
    } t_list_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  i_stall;
    logic [REQ_W-1:0]      i_req_type;
    logic [POS_W-1:0]      i_position;
    logic [VAL_PORT_W-1:0] i_value;
    logic                  o_stall;
    logic                  o_valid;
    logic [VAL_PORT_W-1:0] o_removed_value;
    logic [STAT_W-1:0]     o_status;
    logic [CNT_PORT_W-1:0] o_entry_count;
    logic                  o_is_empty;

    t_list_result          expected_results[$];
    logic [VAL_PORT_W-1:0] list_model[$];
    int                    mismatch_count = 0;
    int                    idle_cycles    = 0;
    int                    hold_req       = 0;
    bit                    send_gaps      = 1'b1;
    bit                    stall_noise    = 1'b1;

    indexed_list_store_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_removed_value(o_removed_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // applies one request to the list copy and returns what the block must answer
    function automatic t_list_result apply_request(logic [REQ_W-1:0] rt,
                                                   logic [POS_W-1:0] pos,
                                                   logic [VAL_PORT_W-1:0] val);
        t_list_result r;
        int           cnt;
        r.removed = '0;
        r.status  = ST_OK;
        cnt       = list_model.size();
        case (rt)
            REQ_ADD_FRONT, REQ_ADD_REAR: begin
                if (cnt >= CAPACITY)
                    r.status = ST_FULL;
                else if (rt == REQ_ADD_FRONT)
                    list_model.push_front(val);
                else
                    list_model.push_back(val);
            end
            REQ_REM_FRONT, REQ_REM_REAR: begin
                if (cnt == 0)
                    r.status = ST_UNDER;
                else if (rt == REQ_REM_FRONT)
                    r.removed = list_model.pop_front();
                else
                    r.removed = list_model.pop_back();
            end
            REQ_INS_AT: begin
                // position is checked before fullness
                if (pos < 1 || pos > cnt + 1)
                    r.status = ST_RANGE;
                else if (cnt >= CAPACITY)
                    r.status = ST_FULL;
                else
                    list_model.insert(pos - 1, val);
            end
            REQ_REM_AT: begin
                if (pos < 1 || pos > cnt) begin
                    r.status = ST_RANGE;
                end else begin
                    r.removed = list_model[pos - 1];
                    list_model.delete(pos - 1);
                end
            end
            default: ;
        endcase
        r.count = CNT_PORT_W'(list_model.size());
        r.empty = (list_model.size() == 0);
        return r;
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] rt, input logic [POS_W-1:0] pos,
                            input logic [VAL_PORT_W-1:0] val);
        int gap;
        gap = (send_gaps && $urandom_range(0, 1)) ? pick_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= rt;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.push_back(apply_request(rt, pos, val));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // mostly well-formed requests against the current count, some noise
    task automatic gen_request(input bit grow, output logic [REQ_W-1:0] rt,
                               output logic [POS_W-1:0] pos,
                               output logic [VAL_PORT_W-1:0] val);
        int r;
        int cnt;
        r   = $urandom_range(0, 99);
        cnt = list_model.size();
        pos = POS_W'($urandom_range(0, 31));
        if (r < 2) begin
            rt = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
        end else if (grow ? (r < 70) : (r < 30)) begin
            case ($urandom_range(0, 2))
                0: rt = REQ_ADD_FRONT;
                1: rt = REQ_ADD_REAR;
                default: begin
                    rt  = REQ_INS_AT;
                    pos = POS_W'($urandom_range(1, cnt + 1));
                end
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0: rt = REQ_REM_FRONT;
                1: rt = REQ_REM_REAR;
                default: begin
                    rt  = REQ_REM_AT;
                    pos = POS_W'($urandom_range(1, (cnt > 0) ? cnt : 1));
                end
            endcase
        end
        if ($urandom_range(0, 99) < 8)
            pos = POS_W'($urandom_range(0, 31));
        r = $urandom_range(0, 9);
        if (r == 0)
            val = '0;
        else if (r == 1)
            val = '1;
        else
            val = $urandom;
    endtask

    task automatic test_empty_list();
        send_req(REQ_REM_FRONT, 5'd0, '0);
        send_req(REQ_REM_REAR, 5'd31, '1);
        send_req(REQ_REM_AT, 5'd1, '0);
        send_req(REQ_INS_AT, 5'd0, 32'h1234_5678);
        send_req(REQ_INS_AT, 5'd2, '0);
        send_req(REQ_SPARE_7, 5'd1, '1);
        wait_drained();
    endtask

    task automatic test_full_list();
        int                    k;
        logic [REQ_W-1:0]      rt;
        logic [POS_W-1:0]      pos;
        logic [VAL_PORT_W-1:0] val;
        for (k = 0; k < CAPACITY; k++) begin
            pos = POS_W'(list_model.size() / 2 + 1);
            case (k % 3)
                0: rt = REQ_ADD_FRONT;
                1: rt = REQ_ADD_REAR;
                default: rt = REQ_INS_AT;
            endcase
            case (k % 4)
                0: val = '0;
                1: val = '1;
                default: val = $urandom;
            endcase
            send_req(rt, pos, val);
        end
        send_req(REQ_ADD_FRONT, 5'd0, 32'hDEAD_BEEF);
        send_req(REQ_INS_AT, 5'd17, 32'hCAFE_F00D);
        send_req(REQ_INS_AT, 5'd18, '1);
        send_req(REQ_SPARE_6, 5'd31, '1);
        send_req(REQ_REM_AT, 5'd17, '0);
        send_req(REQ_REM_AT, 5'd0, '0);
        send_req(REQ_REM_AT, 5'd8, '0);
        send_req(REQ_REM_FRONT, 5'd0, '0);
        send_req(REQ_REM_REAR, 5'd0, '0);
        send_req(REQ_INS_AT, 5'd14, 32'h0000_0001);
        wait_drained();
    endtask

    // receiver holds off while requests keep coming, so the input side stalls
    task automatic test_backpressure();
        logic [REQ_W-1:0]      rt;
        logic [POS_W-1:0]      pos;
        logic [VAL_PORT_W-1:0] val;
        send_gaps   = 1'b0;
        stall_noise = 1'b0;
        hold_req    = 200;
        repeat (48) begin
            gen_request(1'($urandom_range(0, 1)), rt, pos, val);
            send_req(rt, pos, val);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int                    seg;
        int                    n;
        bit                    grow;
        logic [REQ_W-1:0]      rt;
        logic [POS_W-1:0]      pos;
        logic [VAL_PORT_W-1:0] val;
        grow = 1'b1;
        for (seg = 0; seg < RANDOM_SEGS; seg++) begin
            send_gaps   = ($urandom_range(0, 3) != 0);
            stall_noise = ($urandom_range(0, 3) != 0);
            for (n = 0; n < SEG_ITEMS; n++) begin
                if (n % 40 == 0)
                    grow = 1'($urandom_range(0, 1));
                gen_request(grow, rt, pos, val);
                send_req(rt, pos, val);
            end
            if (seg == RANDOM_SEGS / 2)
                wait_drained();
        end
    endtask

    initial begin
        int run;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                run      = hold_req;
                hold_req = 0;
                i_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (stall_noise && $urandom_range(0, 3) == 0) begin
                run = pick_len();
                i_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(input t_list_result exp_r, input t_list_result got_r,
                                 input bit unexpected);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            if (unexpected)
                $display({"%0t: result with no request pending: ",
                          "removed %h status %0d count %0d empty %0b"},
                         $realtime, got_r.removed, got_r.status, got_r.count,
                         got_r.empty);
            else
                $display({"%0t: wrong result: removed %h/%h status %0d/%0d ",
                          "count %0d/%0d empty %0b/%0b (exp/got)"},
                         $realtime, exp_r.removed, got_r.removed, exp_r.status,
                         got_r.status, exp_r.count, got_r.count, exp_r.empty,
                         got_r.empty);
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result got_r;
        t_list_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            got_r = {o_removed_value, o_status, o_entry_count, o_is_empty};
            if (expected_results.size() == 0) begin
                note_mismatch('0, got_r, 1'b1);
            end else begin
                exp_r = expected_results.pop_front();
                if (got_r !== exp_r)
                    note_mismatch(exp_r, got_r, 1'b0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_req_type <= '0;
        i_position <= '0;
        i_value    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_full_list();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
hdl/ils_pkg.sv
hdl/ils_core.sv
hdl/indexed_list_store_top.sv
tb/tb_top.sv
